/* rtl/dept_pkg.sv */
// ----------------------------------------------------------------------------
// dept_pkg
// Shared types and constants of the double-ended priority table.
// ----------------------------------------------------------------------------
package dept_pkg;

  localparam int CAPACITY   = 256;
  localparam int KEY_BITS   = 16;
  localparam int LEVEL_BITS = 7;
  localparam int OCC_BITS   = $clog2(CAPACITY + 1);

  localparam int GROUP_SIZE  = 16;
  localparam int GROUPS      = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int TREE_LEAVES = GROUPS * GROUP_SIZE;

  localparam logic [OCC_BITS-1:0] OCC_FULL = OCC_BITS'(CAPACITY);
  localparam logic [OCC_BITS-1:0] OCC_ONE  = OCC_BITS'(1);

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_QUERY_HARD = 2'd2,
    OP_QUERY_EASY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_REDUCE,
    S_DECIDE,
    S_INSERT,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [LEVEL_BITS-1:0] level;
  } entry_t;

  // Broadcast to every cell of a chain.
  typedef struct packed {
    logic                  remove;
    logic                  insert;
    logic [KEY_BITS-1:0]   key;
    logic [LEVEL_BITS-1:0] level;
  } cmd_t;

endpackage

/* rtl/dept_req_if.sv */
// ----------------------------------------------------------------------------
// dept_req_if
// Request channel: operation, key and level with valid/ready.
// ----------------------------------------------------------------------------
interface dept_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      operation;
  logic [dept_pkg::KEY_BITS-1:0]   entry_key;
  logic [dept_pkg::LEVEL_BITS-1:0] entry_level;

  modport source (output valid, output operation, output entry_key, output entry_level,
                  input ready);
  modport sink   (input valid, input operation, input entry_key, input entry_level,
                  output ready);
endinterface

/* rtl/dept_rsp_if.sv */
// ----------------------------------------------------------------------------
// dept_rsp_if
// Response channel: result key and status with valid/ready.
// ----------------------------------------------------------------------------
interface dept_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dept_pkg::KEY_BITS-1:0] result_key;
  logic [1:0]                    status;

  modport source (output valid, output result_key, output status, input ready);
  modport sink   (input valid, input result_key, input status, output ready);
endinterface

/* rtl/dept_cell.sv */
// ----------------------------------------------------------------------------
// dept_cell
// One slot of a sorted chain. Keeps its entry, compares it with the
// broadcast entry and shifts from a neighbor on remove or insert, or takes the broadcast entry on insert.
// ----------------------------------------------------------------------------
module dept_cell (
  input  logic             clk,
  input  logic             rst,
  input  dept_pkg::cmd_t   cmd,
  input  dept_pkg::entry_t prev,
  input  logic             prev_above,
  input  dept_pkg::entry_t next,
  output dept_pkg::entry_t slot,
  output logic             above,
  output logic             match
);

  dept_pkg::entry_t slot_next;

  assign above = slot.valid &&
                 ((slot.level > cmd.level) ||
                  ((slot.level == cmd.level) && (slot.key > cmd.key)));
  assign match = slot.valid && (slot.key == cmd.key);

  always_comb begin
    slot_next = slot;
    if (cmd.remove) begin
      if (slot.valid && !above) begin
        slot_next = next;
      end
    end else if (cmd.insert) begin
      if (!above) begin
        if (prev_above) begin
          slot_next.valid = 1'b1;
          slot_next.key   = cmd.key;
          slot_next.level = cmd.level;
        end else begin
          slot_next = prev;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

/* rtl/dept_chain.sv */
// ----------------------------------------------------------------------------
// dept_chain
// Row of cells kept sorted in descending rank, valid entries packed from
// cell 0. Cell 0 holds the top-ranked entry.
// ----------------------------------------------------------------------------
module dept_chain (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  dept_pkg::cmd_t                                          cmd,
  output dept_pkg::entry_t                                        head,
  output logic [dept_pkg::CAPACITY-1:0]                           match,
  output logic [dept_pkg::CAPACITY-1:0][dept_pkg::LEVEL_BITS-1:0] level
);

  dept_pkg::entry_t                     slots [dept_pkg::CAPACITY];
  logic [dept_pkg::CAPACITY-1:0]        above;

  for (genvar i = 0; i < dept_pkg::CAPACITY; i++) begin : g_cell
    dept_pkg::entry_t prev_e;
    dept_pkg::entry_t next_e;
    logic             prev_a;

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_a = 1'b1;
    end else begin : g_inner
      assign prev_e = slots[i-1];
      assign prev_a = above[i-1];
    end

    if (i == dept_pkg::CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_body
      assign next_e = slots[i+1];
    end

    dept_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev       (prev_e),
      .prev_above (prev_a),
      .next       (next_e),
      .slot       (slots[i]),
      .above      (above[i]),
      .match      (match[i])
    );

    assign level[i] = slots[i].level;
  end

  assign head = slots[0];

endmodule

/* rtl/dept_match_tree.sv */
// ----------------------------------------------------------------------------
// dept_match_tree
// Two-stage registered OR tree: whether a key is held, and its level.
// ----------------------------------------------------------------------------
module dept_match_tree (
  input  logic                                                    clk,
  input  logic [dept_pkg::CAPACITY-1:0]                           match,
  input  logic [dept_pkg::CAPACITY-1:0][dept_pkg::LEVEL_BITS-1:0] level,
  output logic                                                    found,
  output logic [dept_pkg::LEVEL_BITS-1:0]                         found_level
);

  logic [dept_pkg::TREE_LEAVES-1:0]                            match_pad;
  logic [dept_pkg::TREE_LEAVES-1:0][dept_pkg::LEVEL_BITS-1:0]  level_m;
  logic [dept_pkg::GROUPS-1:0]                                 grp_found;
  logic [dept_pkg::GROUPS-1:0][dept_pkg::LEVEL_BITS-1:0]       grp_level;
  logic                                                        found_next;
  logic [dept_pkg::LEVEL_BITS-1:0]                             found_level_next;

  for (genvar k = 0; k < dept_pkg::TREE_LEAVES; k++) begin : g_leaf
    if (k < dept_pkg::CAPACITY) begin : g_used
      assign match_pad[k] = match[k];
      assign level_m[k]   = match[k] ? level[k] : '0;
    end else begin : g_pad
      assign match_pad[k] = 1'b0;
      assign level_m[k]   = '0;
    end
  end

  for (genvar g = 0; g < dept_pkg::GROUPS; g++) begin : g_group
    logic [dept_pkg::LEVEL_BITS-1:0] lv;

    always_comb begin
      lv = '0;
      for (int j = 0; j < dept_pkg::GROUP_SIZE; j++) begin
        lv = lv | level_m[g*dept_pkg::GROUP_SIZE + j];
      end
    end

    always_ff @(posedge clk) begin
      grp_found[g] <= |match_pad[g*dept_pkg::GROUP_SIZE +: dept_pkg::GROUP_SIZE];
      grp_level[g] <= lv;
    end
  end

  always_comb begin
    found_next       = |grp_found;
    found_level_next = '0;
    for (int g = 0; g < dept_pkg::GROUPS; g++) begin
      found_level_next = found_level_next | grp_level[g];
    end
  end

  always_ff @(posedge clk) begin
    found       <= found_next;
    found_level <= found_level_next;
  end

endmodule

/* rtl/double_ended_priority_table.sv */
// ----------------------------------------------------------------------------
// double_ended_priority_table
// Bounded table of (key, level) entries answering hardest/easiest queries.
// ----------------------------------------------------------------------------
// Entries live in two sorted cell chains, one ranked hardest-first and one
// easiest-first (it stores inverted key and level), so both query answers
// sit in the head cells, which a query reads when it is accepted.
// Add and remove first look the key up through a two-stage registered match
// tree, then shift the chains: a found key is removed in S_DECIDE, and an
// accepted add (new key or level update) is inserted in S_INSERT, so an
// update is a remove pass followed by an insert pass.
// One request is in flight at a time; a finished response waits in an
// output register while the next request is accepted.
// ----------------------------------------------------------------------------
module double_ended_priority_table (
  input logic        clk,
  input logic        rst,
  dept_req_if.sink   req,
  dept_rsp_if.source rsp
);

  dept_pkg::state_t                state, state_next;
  dept_pkg::op_t                   req_op, req_op_next;
  logic [dept_pkg::KEY_BITS-1:0]   req_key, req_key_next;
  logic [dept_pkg::LEVEL_BITS-1:0] req_level, req_level_next;
  logic [dept_pkg::OCC_BITS-1:0]   occupancy, occupancy_next;
  logic [dept_pkg::KEY_BITS-1:0]   res_key, res_key_next;
  dept_pkg::status_t               res_status, res_status_next;
  logic                            rsp_valid;
  logic [dept_pkg::KEY_BITS-1:0]   rsp_key;
  dept_pkg::status_t               rsp_status;
  logic                            rsp_load;

  dept_pkg::cmd_t                  cmd, cmd_b;
  dept_pkg::entry_t                head_a, head_b;
  logic [dept_pkg::CAPACITY-1:0]   match_a;
  logic [dept_pkg::CAPACITY-1:0][dept_pkg::LEVEL_BITS-1:0] level_a;
  logic                            found;
  logic [dept_pkg::LEVEL_BITS-1:0] found_level;

  assign cmd_b.remove = cmd.remove;
  assign cmd_b.insert = cmd.insert;
  assign cmd_b.key    = ~cmd.key;
  assign cmd_b.level  = ~cmd.level;

  dept_chain u_chain_hard (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .head  (head_a),
    .match (match_a),
    .level (level_a)
  );

  dept_chain u_chain_easy (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_b),
    .head  (head_b),
    .match (),
    .level ()
  );

  dept_match_tree u_tree (
    .clk         (clk),
    .match       (match_a),
    .level       (level_a),
    .found       (found),
    .found_level (found_level)
  );

  assign req.ready      = (state == dept_pkg::S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.result_key = rsp_key;
  assign rsp.status     = rsp_status;

  always_comb begin
    state_next      = state;
    req_op_next     = req_op;
    req_key_next    = req_key;
    req_level_next  = req_level;
    occupancy_next  = occupancy;
    res_key_next    = res_key;
    res_status_next = res_status;
    rsp_load        = 1'b0;
    cmd             = '0;
    cmd.key         = req_key;
    cmd.level       = req_level;
    case (state)
      dept_pkg::S_IDLE: begin
        if (req.valid) begin
          req_op_next     = dept_pkg::op_t'(req.operation);
          req_key_next    = req.entry_key;
          req_level_next  = req.entry_level;
          res_key_next    = '0;
          res_status_next = dept_pkg::ST_OK;
          case (dept_pkg::op_t'(req.operation))
            dept_pkg::OP_QUERY_HARD, dept_pkg::OP_QUERY_EASY: begin
              state_next = dept_pkg::S_REPLY;
              if (occupancy == '0) begin
                res_status_next = dept_pkg::ST_EMPTY;
              end else if (dept_pkg::op_t'(req.operation) == dept_pkg::OP_QUERY_HARD) begin
                res_key_next = head_a.key;
              end else begin
                res_key_next = ~head_b.key;
              end
            end
            default: begin
              state_next = dept_pkg::S_FIND;
            end
          endcase
        end
      end
      dept_pkg::S_FIND: begin
        state_next = dept_pkg::S_REDUCE;
      end
      dept_pkg::S_REDUCE: begin
        state_next = dept_pkg::S_DECIDE;
      end
      dept_pkg::S_DECIDE: begin
        state_next = dept_pkg::S_REPLY;
        if (found) begin
          cmd.remove     = 1'b1;
          cmd.level      = found_level;
          occupancy_next = occupancy - dept_pkg::OCC_ONE;
          if (req_op == dept_pkg::OP_ADD) begin
            state_next = dept_pkg::S_INSERT;
          end
        end else if (req_op == dept_pkg::OP_REMOVE) begin
          res_status_next = dept_pkg::ST_ABSENT;
        end else if (occupancy == dept_pkg::OCC_FULL) begin
          res_status_next = dept_pkg::ST_FULL;
        end else begin
          state_next = dept_pkg::S_INSERT;
        end
      end
      dept_pkg::S_INSERT: begin
        cmd.insert     = 1'b1;
        occupancy_next = occupancy + dept_pkg::OCC_ONE;
        state_next     = dept_pkg::S_REPLY;
      end
      dept_pkg::S_REPLY: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = dept_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dept_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dept_pkg::S_IDLE;
      occupancy <= '0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
    end
  end

  always_ff @(posedge clk) begin
    req_op     <= req_op_next;
    req_key    <= req_key_next;
    req_level  <= req_level_next;
    res_key    <= res_key_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_key    <= res_key;
      rsp_status <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= dept_pkg::OCC_FULL)
    else $error("occupancy above capacity");

  a_heads_track_occ: assert property (@(posedge clk) disable iff (rst)
    (head_a.valid == (occupancy != '0)) && (head_b.valid == (occupancy != '0)))
    else $error("chain heads disagree with occupancy");

  a_single_entry: assert property (@(posedge clk) disable iff (rst)
    occupancy == dept_pkg::OCC_ONE |->
      (head_a.key == ~head_b.key) && (head_a.level == ~head_b.level))
    else $error("chains hold different single entries");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_load && (res_status == dept_pkg::ST_FULL) |-> occupancy == dept_pkg::OCC_FULL)
    else $error("full status with free slots");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> (state == dept_pkg::S_FIND) || (state == dept_pkg::S_REPLY))
    else $error("accepted request not dispatched");
`endif

endmodule
